// ===== hw/rtl/grc_pkg.sv =====
// Package for the grid ray wall caster: payload structs, sizes and constants.
// Depends on nothing; grid_ray_wall_caster uses it.
`timescale 1ns / 1ps
package grc_pkg;
	localparam int MAP_COLS_DEF  = 64;
	localparam int MAP_ROWS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic       MODE_WRITE = 1'b0;
	localparam logic       MODE_CAST  = 1'b1;
	localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

	localparam logic [23:0] COLOR_X_POS = 24'hFF0000;
	localparam logic [23:0] COLOR_X_NEG = 24'h00FF00;
	localparam logic [23:0] COLOR_Y_POS = 24'h0000FF;
	localparam logic [23:0] COLOR_Y_NEG = 24'hFFFF00;

	typedef struct packed {
		logic        mode;
		logic [5:0]  grid_x;
		logic [5:0]  grid_y;
		logic        cell_is_wall;
		logic [31:0] side_dist_x;
		logic [31:0] side_dist_y;
		logic [31:0] delta_dist_x;
		logic [31:0] delta_dist_y;
		logic        step_x_negative;
		logic        step_y_negative;
		logic        ray_dir_x_positive;
		logic        ray_dir_y_positive;
	} in_item_t;

	typedef struct packed {
		logic        hit_side;
		logic [7:0]  hit_col;
		logic [7:0]  hit_row;
		logic [31:0] perp_distance;
		logic [15:0] wall_height;
		logic [10:0] draw_start;
		logic [10:0] draw_end;
		logic [23:0] wall_color;
	} out_item_t;
endpackage

// ===== hw/rtl/grid_ray_wall_caster.sv =====
// Grid ray wall caster: wall bitmap in one synchronous RAM plus a DDA walker.
// A map write is registered into the RAM. Each DDA step passes through a RAM
// read state and then a test state; the ray then runs the line-height divider and finish.
// One item is in work at a time; the result sits in an output register.
// Reset clears control registers and loads the configuration registers with defaults;
// the map RAM is not cleared and must be written before cells are read.
`timescale 1ns / 1ps
module grid_ray_wall_caster #(
	parameter int MAP_COLS  = grc_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS  = grc_pkg::MAP_ROWS_DEF,
	parameter int FRAC_BITS = grc_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  grc_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output grc_pkg::out_item_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [11:0]       cfg_data
);
	localparam int CB = $clog2(MAP_COLS);
	localparam int RB = $clog2(MAP_ROWS);
	localparam int NUM_W = 12 + FRAC_BITS;
	localparam logic [31:0] TENTH = 32'(((1 << FRAC_BITS) + 5) / 10);

	// One-hot controller states.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_STEP = 6'b000010,
		ST_TEST = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;
	state_t state_q;

	logic [6:0]  map_width_q, map_height_q;
	logic [11:0] screen_height_q;

	// The wall map: one bit per cell, addressed by {row, column}.
	logic wall_mem [1 << (CB + RB)];
	logic rd_bit_s1;

	logic [31:0] sdx_q, sdy_q, ddx_q, ddy_q;
	logic [9:0]  col_q, row_q;
	logic        stxn_q, styn_q, rdxp_q, rdyp_q, side_q;
	logic [31:0] perp_q;
	logic [8:0]  wq, hq;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q     <= 7'd64;
			map_height_q    <= 7'd64;
			screen_height_q <= 12'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				grc_pkg::REG_MAP_WIDTH:     map_width_q     <= cfg_data[6:0];
				grc_pkg::REG_MAP_HEIGHT:    map_height_q    <= cfg_data[6:0];
				grc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective map size, clamped to the store.
	always_comb begin
		wq = ({2'b0, map_width_q} > 9'(MAP_COLS)) ? 9'(MAP_COLS) : {2'b0, map_width_q};
		hq = ({2'b0, map_height_q} > 9'(MAP_ROWS)) ? 9'(MAP_ROWS) : {2'b0, map_height_q};
	end

	// Next DDA step, computed from the registered walker state.
	logic        step_x;
	logic [32:0] sum_x, sum_y;
	logic [9:0]  ncol, nrow;
	logic        n_out;
	assign step_x = sdx_q < sdy_q;
	assign sum_x  = {1'b0, sdx_q} + {1'b0, ddx_q};
	assign sum_y  = {1'b0, sdy_q} + {1'b0, ddy_q};
	assign ncol   = step_x ? (stxn_q ? col_q - 10'd1 : col_q + 10'd1) : col_q;
	assign nrow   = step_x ? row_q : (styn_q ? row_q - 10'd1 : row_q + 10'd1);
	assign n_out  = ncol[9] || nrow[9] || (ncol >= {1'b0, wq}) || (nrow >= {1'b0, hq});

	logic wr_en;
	logic [CB+RB-1:0] wr_addr, rd_addr;
	assign wr_en   = in_valid && in_ready && (in_data.mode == grc_pkg::MODE_WRITE)
		&& ({26'b0, in_data.grid_x} < 32'(MAP_COLS))
		&& ({26'b0, in_data.grid_y} < 32'(MAP_ROWS));
	assign wr_addr = {RB'({2'b0, in_data.grid_y}), CB'({2'b0, in_data.grid_x})};
	assign rd_addr = {RB'(nrow), CB'(ncol)};

	always_ff @(posedge clk) begin
		if (wr_en) wall_mem[wr_addr] <= in_data.cell_is_wall;
		rd_bit_s1 <= wall_mem[rd_addr];
	end

	logic div_start, div_done;
	logic [NUM_W-1:0] quo;
	grc_divider #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({screen_height_q, FRAC_BITS'(0)}), .den(perp_q),
		.done(div_done), .quo(quo)
	);
	assign div_start = (state_q == ST_DIV);

	logic out_n_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			// A new result may replace one that is taken in the same cycle.
			if (state_q == ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_data.mode == grc_pkg::MODE_CAST) state_q <= ST_STEP;
				ST_STEP: state_q <= ST_TEST;
				ST_TEST: if (out_n_q || rd_bit_s1) state_q <= ST_DIV; else state_q <= ST_STEP;
				ST_DIV:  state_q <= ST_WAIT;
				ST_WAIT: if (div_done) state_q <= ST_OUT;
				ST_OUT:  if (!out_valid || out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output values derived once the quotient is known.
	logic [15:0] lh;
	logic [12:0] ds_w, de_w;
	always_comb begin
		lh   = (quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
		ds_w = (lh[15:1] > {4'b0, screen_height_q[11:1]}) ? 13'd0 :
			13'({4'b0, screen_height_q[11:1]} - lh[15:1]);
		if (32'(lh[15:1]) + 32'(screen_height_q[11:1]) >= 32'(screen_height_q))
			de_w = (screen_height_q == 12'd0) ? 13'd0 : 13'(screen_height_q - 12'd1);
		else
			de_w = 13'(lh[15:1]) + 13'(screen_height_q[11:1]);
		if (de_w > 13'd2047) de_w = 13'd2047;
	end

	// Distance along the axis of the last step, before the zero floor.
	logic [31:0] perp_raw;
	assign perp_raw = side_q ? sdy_q - ddy_q : sdx_q - ddx_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sdx_q  <= in_data.side_dist_x;
				sdy_q  <= in_data.side_dist_y;
				ddx_q  <= in_data.delta_dist_x;
				ddy_q  <= in_data.delta_dist_y;
				col_q  <= {4'b0, in_data.grid_x};
				row_q  <= {4'b0, in_data.grid_y};
				stxn_q <= in_data.step_x_negative;
				styn_q <= in_data.step_y_negative;
				rdxp_q <= in_data.ray_dir_x_positive;
				rdyp_q <= in_data.ray_dir_y_positive;
			end
			ST_STEP: begin
				// The RAM reads the new cell this cycle; commit the step.
				out_n_q <= n_out;
				side_q  <= ~step_x;
				col_q   <= ncol;
				row_q   <= nrow;
				if (step_x) sdx_q <= sum_x[32] ? 32'hFFFFFFFF : sum_x[31:0];
				else        sdy_q <= sum_y[32] ? 32'hFFFFFFFF : sum_y[31:0];
			end
			ST_TEST: perp_q <= (perp_raw == 32'd0) ? TENTH : perp_raw;
			ST_OUT: if (!out_valid || out_ready) begin
				out_data.hit_side      <= side_q;
				out_data.hit_col       <= col_q[7:0];
				out_data.hit_row       <= row_q[7:0];
				out_data.perp_distance <= perp_q;
				out_data.wall_height   <= lh;
				out_data.draw_start    <= ds_w[10:0];
				out_data.draw_end      <= de_w[10:0];
				out_data.wall_color    <= side_q ?
					(rdyp_q ? grc_pkg::COLOR_Y_POS : grc_pkg::COLOR_Y_NEG) :
					(rdxp_q ? grc_pkg::COLOR_X_POS : grc_pkg::COLOR_X_NEG);
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("result appeared outside the finish state");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |=> !in_ready)
		else $error("input taken during a walk");
`endif
endmodule

// ===== hw/rtl/grc_divider.sv =====
// Restoring radix-2 divider for the line height: one quotient bit per cycle.
// Depends on nothing; widths follow its parameters.
`timescale 1ns / 1ps
module grc_divider #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule
